// ===== hw/rtl/hsl2rgb_pkg.sv =====
// shared types, constants and helpers for the hsl to rgb converter
`default_nettype none

package hsl2rgb_pkg;

  // fixed-point format of all pixel fields
  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 16;
  localparam int NUM_CH    = 3;

  // internal widths: q, p and their difference carry 2*FRAC_BITS fraction bits
  localparam int WIDE_W = 2 * FRAC_BITS + 1;
  localparam int X_W    = FRAC_BITS + 1;
  localparam int U_W    = FRAC_BITS + 4;
  localparam int PROD_W = WIDE_W + X_W;
  localparam int SUM_W  = WIDE_W + 1;
  localparam int RES_W  = SUM_W - FRAC_BITS;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  // hue position constants, six units per full circle
  localparam logic [U_W-1:0] ONE_U   = U_W'(1) << FRAC_BITS;
  localparam logic [U_W-1:0] THREE_U = U_W'(3) << FRAC_BITS;
  localparam logic [U_W-1:0] FOUR_U  = U_W'(4) << FRAC_BITS;
  localparam logic [U_W-1:0] SIX_U   = U_W'(6) << FRAC_BITS;

  // per-channel hue offsets: red +1/3, green 0, blue -1/3 (as +2/3)
  localparam logic [NUM_CH-1:0][U_W-1:0] CH_OFFSET = {
    U_W'(4) << FRAC_BITS,
    U_W'(0),
    U_W'(2) << FRAC_BITS
  };

  localparam logic [FIELD_W-1:0] HALF_L    = FIELD_W'(1) << (FRAC_BITS - 1);
  localparam logic [SUM_W-1:0]   ROUND_ADD = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic [RES_W-1:0]   FIELD_MAX = RES_W'({FIELD_W{1'b1}});

  typedef struct packed {
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] lightness;
  } hsl_pix_t;

  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } rgb_pix_t;

  // classified pixel: v = p + (a * x) >> FRAC_BITS per channel
  typedef struct packed {
    logic [WIDE_W-1:0]              p;
    logic [WIDE_W-1:0]              a;
    logic [NUM_CH-1:0][X_W-1:0]     x;
  } ramp_item_t;

  // ramp weight for one channel: 0 in the p segment, one in the q segment, a linear ramp between
  function automatic logic [X_W-1:0] ramp_weight(input logic [U_W-1:0] base,
                                                 input logic [U_W-1:0] offset);
    logic [U_W-1:0] u;
    logic [U_W-1:0] w;
    u = base + offset;
    if (u >= SIX_U) begin
      u = u - SIX_U;
    end
    if (u < ONE_U) begin
      w = u;
    end else if (u < THREE_U) begin
      w = ONE_U;
    end else if (u < FOUR_U) begin
      w = FOUR_U - u;
    end else begin
      w = '0;
    end
    return w[X_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hsl2rgb_front.sv =====
// front part: takes pixels, forms q, p and per-channel ramp weights
`default_nettype none

module hsl2rgb_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire hsl2rgb_pkg::hsl_pix_t  in_data,
  input  wire logic                   q_full,
  output logic                        push,
  output hsl2rgb_pkg::ramp_item_t     push_item
);

  // stage valids
  logic s1_v_r, s2_v_r, s3_v_r;
  logic rdy1, rdy2, rdy3;

  // stage 1: lightness times saturation, six times hue
  logic [hsl2rgb_pkg::FIELD_W-1:0]   s1_s_r, s1_l_r;
  logic [2*hsl2rgb_pkg::FIELD_W-1:0] s1_ls_r, s1_ls_nxt;
  logic [hsl2rgb_pkg::U_W-1:0]       s1_base_r, s1_base_nxt;

  // stage 2: q and weights
  logic [hsl2rgb_pkg::FIELD_W-1:0]                         s2_l_r;
  logic [hsl2rgb_pkg::WIDE_W-1:0]                          s2_q_r, s2_q_nxt;
  logic [hsl2rgb_pkg::NUM_CH-1:0][hsl2rgb_pkg::X_W-1:0]    s2_x_r, s2_x_nxt;

  // stage 3: p and q minus p
  hsl2rgb_pkg::ramp_item_t s3_item_r, s3_item_nxt;

  // handshake chain
  assign rdy3     = !s3_v_r || !q_full;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_stall = !rdy1;
  assign push     = s3_v_r && !q_full;
  assign push_item = s3_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
    end
  end

  // stage 1 math
  always_comb begin
    logic [hsl2rgb_pkg::U_W-1:0] h;
    h = hsl2rgb_pkg::U_W'(in_data.hue[hsl2rgb_pkg::FRAC_BITS-1:0]);
    s1_ls_nxt = (2*hsl2rgb_pkg::FIELD_W)'(in_data.lightness)
              * (2*hsl2rgb_pkg::FIELD_W)'(in_data.saturation);
    s1_base_nxt = (h << 2) + (h << 1);
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_s_r    <= in_data.saturation;
      s1_l_r    <= in_data.lightness;
      s1_ls_r   <= s1_ls_nxt;
      s1_base_r <= s1_base_nxt;
    end
  end

  // stage 2 math: q by lightness half, weights by hue segment
  always_comb begin
    logic [hsl2rgb_pkg::WIDE_W-1:0] l_w, s_w, ls_w;
    l_w  = hsl2rgb_pkg::WIDE_W'(s1_l_r);
    s_w  = hsl2rgb_pkg::WIDE_W'(s1_s_r);
    ls_w = hsl2rgb_pkg::WIDE_W'(s1_ls_r);
    if (s1_l_r < hsl2rgb_pkg::HALF_L) begin
      s2_q_nxt = (l_w << hsl2rgb_pkg::FRAC_BITS) + ls_w;
    end else begin
      s2_q_nxt = ((l_w + s_w) << hsl2rgb_pkg::FRAC_BITS) - ls_w;
    end
    for (int ch = 0; ch < hsl2rgb_pkg::NUM_CH; ch++) begin
      s2_x_nxt[ch] = hsl2rgb_pkg::ramp_weight(s1_base_r, hsl2rgb_pkg::CH_OFFSET[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_l_r <= s1_l_r;
      s2_q_r <= s2_q_nxt;
      s2_x_r <= s2_x_nxt;
    end
  end

  // stage 3 math: p = 2l - q, a = q - p
  always_comb begin
    logic [hsl2rgb_pkg::WIDE_W-1:0] l2;
    l2 = hsl2rgb_pkg::WIDE_W'(s2_l_r) << (hsl2rgb_pkg::FRAC_BITS + 1);
    s3_item_nxt.p = l2 - s2_q_r;
    s3_item_nxt.a = (s2_q_r << 1) - l2;
    s3_item_nxt.x = s2_x_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_item_r <= s3_item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hsl2rgb_queue.sv =====
// short queue of classified pixels between front and back
`default_nettype none

module hsl2rgb_queue (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire hsl2rgb_pkg::ramp_item_t  push_item,
  input  wire logic                     pop,
  output logic                          full,
  output logic                          nonempty,
  output hsl2rgb_pkg::ramp_item_t       head
);

  hsl2rgb_pkg::ramp_item_t slot_r [hsl2rgb_pkg::Q_DEPTH];
  logic [hsl2rgb_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [hsl2rgb_pkg::Q_CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == hsl2rgb_pkg::Q_CNT_W'(hsl2rgb_pkg::Q_DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = slot_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> nonempty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= hsl2rgb_pkg::Q_CNT_W'(hsl2rgb_pkg::Q_DEPTH))
    else $error("queue count beyond depth");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
      (wr_ptr_r - rd_ptr_r) == count_r[hsl2rgb_pkg::Q_PTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== hw/rtl/hsl2rgb_back.sv =====
// back part: ramp products, rounding, saturation and output register
`default_nettype none

module hsl2rgb_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_nonempty,
  input  wire hsl2rgb_pkg::ramp_item_t  q_head,
  output logic                          pop,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output hsl2rgb_pkg::rgb_pix_t         out_data
);

  logic b1_v_r, ov_r;
  logic rdy_b1, rdy_b2;

  logic [hsl2rgb_pkg::WIDE_W-1:0]                         b1_p_r;
  logic [hsl2rgb_pkg::NUM_CH-1:0][hsl2rgb_pkg::PROD_W-1:0] b1_prod_r, b1_prod_nxt;
  logic [hsl2rgb_pkg::NUM_CH-1:0][hsl2rgb_pkg::FIELD_W-1:0] res_nxt;
  hsl2rgb_pkg::rgb_pix_t od_r;

  // handshake chain
  assign rdy_b2    = !ov_r || !out_stall;
  assign rdy_b1    = !b1_v_r || rdy_b2;
  assign pop       = q_nonempty && rdy_b1;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (rdy_b1) b1_v_r <= q_nonempty;
      if (rdy_b2) ov_r   <= b1_v_r;
    end
  end

  // one multiplier per channel: (q - p) times weight
  always_comb begin
    for (int ch = 0; ch < hsl2rgb_pkg::NUM_CH; ch++) begin
      b1_prod_nxt[ch] = hsl2rgb_pkg::PROD_W'(q_head.a) * hsl2rgb_pkg::PROD_W'(q_head.x[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b1) begin
      b1_p_r    <= q_head.p;
      b1_prod_r <= b1_prod_nxt;
    end
  end

  // add base, round half up, clamp to field maximum
  always_comb begin
    logic [hsl2rgb_pkg::SUM_W-1:0] v;
    logic [hsl2rgb_pkg::RES_W-1:0] r;
    for (int ch = 0; ch < hsl2rgb_pkg::NUM_CH; ch++) begin
      v = hsl2rgb_pkg::SUM_W'(b1_p_r)
        + b1_prod_r[ch][hsl2rgb_pkg::PROD_W-1:hsl2rgb_pkg::FRAC_BITS]
        + hsl2rgb_pkg::ROUND_ADD;
      r = v[hsl2rgb_pkg::SUM_W-1:hsl2rgb_pkg::FRAC_BITS];
      if (r > hsl2rgb_pkg::FIELD_MAX) begin
        res_nxt[ch] = hsl2rgb_pkg::FIELD_MAX[hsl2rgb_pkg::FIELD_W-1:0];
      end else begin
        res_nxt[ch] = r[hsl2rgb_pkg::FIELD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b2) begin
      od_r.red   <= res_nxt[0];
      od_r.green <= res_nxt[1];
      od_r.blue  <= res_nxt[2];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hsl_to_rgb_convert.sv =====
// an input transfer passes front stages s1, s2, s3, the queue, then b1 and the output register to out_valid
// throughput: one pixel per cycle while out_stall is low, set by the three-stage front, queue and two-stage back
// a 4-entry queue lets the front keep taking pixels while the output is stalled
// reset (rst_n low, synchronous) empties all stages and the queue; no clearing pass
// top level: hsl to rgb pixel converter
`default_nettype none

module hsl_to_rgb_convert (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire hsl2rgb_pkg::hsl_pix_t  in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output hsl2rgb_pkg::rgb_pix_t       out_data
);

  logic q_full, q_nonempty, push, pop;
  hsl2rgb_pkg::ramp_item_t push_item, q_head;

  // classify pixels
  hsl2rgb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  hsl2rgb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  // ramp and output
  hsl2rgb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the hsl to rgb pixel converter
module tb_top;

  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 24;

  // expected rgb pixels in transfer order, computed from accepted hsl pixels
  class pixel_scoreboard;
    hsl2rgb_pkg::rgb_pix_t expected_rgb_q[$];
    int unsigned n_in;
    int unsigned n_out;
    int unsigned n_gray;
    int unsigned n_full;
    int unsigned n_errors;

    // one channel: flat at p or q, or a linear ramp between them
    function logic [hsl2rgb_pkg::FIELD_W-1:0] channel_level(longint p, longint q, longint u);
      longint          one;
      longint          v;
      longint          a;
      longint unsigned mag;
      longint unsigned x;
      longint unsigned r;
      one = longint'(1) << hsl2rgb_pkg::FRAC_BITS;
      if (u >= one && u < 3 * one) begin
        v = q;
      end else if (u >= 4 * one) begin
        v = p;
      end else begin
        x   = (u < one) ? u : 4 * one - u;
        a   = q - p;
        mag = (a < 0) ? -a : a;
        // ramp term truncated toward zero
        if (a < 0) begin
          v = p - longint'((mag * x) >> hsl2rgb_pkg::FRAC_BITS);
        end else begin
          v = p + longint'((mag * x) >> hsl2rgb_pkg::FRAC_BITS);
        end
      end
      if (v < 0) begin
        return '0;
      end
      // round half up, clip to full scale
      r = longint'(v + (one >> 1)) >> hsl2rgb_pkg::FRAC_BITS;
      if (r > {hsl2rgb_pkg::FIELD_W{1'b1}}) begin
        return {hsl2rgb_pkg::FIELD_W{1'b1}};
      end
      return r[hsl2rgb_pkg::FIELD_W-1:0];
    endfunction

    function hsl2rgb_pkg::rgb_pix_t rgb_from_hsl(hsl2rgb_pkg::hsl_pix_t px);
      hsl2rgb_pkg::rgb_pix_t rgb;
      longint   one;
      longint   h;
      longint   s;
      longint   l;
      longint   q;
      longint   p;
      longint   base;
      one = longint'(1) << hsl2rgb_pkg::FRAC_BITS;
      h   = longint'(px.hue) & (one - 1);
      s   = longint'(px.saturation);
      l   = longint'(px.lightness);
      // gray pixel passes lightness straight through
      if (s == 0) begin
        rgb.red   = px.lightness;
        rgb.green = px.lightness;
        rgb.blue  = px.lightness;
        return rgb;
      end
      if (l < (one >> 1)) begin
        q = l * (one + s);
      end else begin
        q = (l + s) * one - l * s;
      end
      p    = 2 * l * one - q;
      base = 6 * h;
      rgb.red   = channel_level(p, q, (base + 2 * one) % (6 * one));
      rgb.green = channel_level(p, q, base % (6 * one));
      rgb.blue  = channel_level(p, q, (base + 4 * one) % (6 * one));
      return rgb;
    endfunction

    function void note_pixel(hsl2rgb_pkg::hsl_pix_t px);
      hsl2rgb_pkg::rgb_pix_t rgb;
      rgb = rgb_from_hsl(px);
      expected_rgb_q.push_back(rgb);
      n_in++;
      if (px.saturation == '0) begin
        n_gray++;
      end else if (&rgb.red || &rgb.green || &rgb.blue) begin
        n_full++;
      end
    endfunction

    function void check_pixel(hsl2rgb_pkg::rgb_pix_t got);
      hsl2rgb_pkg::rgb_pix_t want;
      if (expected_rgb_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("unexpected result at %0t: rgb %h %h %h", $time,
                   got.red, got.green, got.blue);
        end
        return;
      end
      want = expected_rgb_q.pop_front();
      n_out++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("mismatch on result %0d at %0t: expected rgb %h %h %h, got %h %h %h",
                   n_out, $time, want.red, want.green, want.blue,
                   got.red, got.green, got.blue);
        end
      end
    endfunction

    function int pending();
      return expected_rgb_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  hsl2rgb_pkg::hsl_pix_t in_data;
  logic                  out_valid;
  logic                  out_stall;
  hsl2rgb_pkg::rgb_pix_t out_data;

  pixel_scoreboard sb;
  int unsigned     idle_cycles = 0;
  bit              hold_off_req = 1'b0;
  bit              rx_no_idle = 1'b0;

  hsl_to_rgb_convert i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // field value biased toward the ends and the midpoint
  function automatic logic [hsl2rgb_pkg::FIELD_W-1:0] pick_field();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return hsl2rgb_pkg::FIELD_W'(16'h8000);
      3: return hsl2rgb_pkg::FIELD_W'(16'h7fff);
      default: return hsl2rgb_pkg::FIELD_W'($urandom);
    endcase
  endfunction

  function automatic hsl2rgb_pkg::hsl_pix_t make_hsl(logic [hsl2rgb_pkg::FIELD_W-1:0] h,
                                                     logic [hsl2rgb_pkg::FIELD_W-1:0] s,
                                                     logic [hsl2rgb_pkg::FIELD_W-1:0] l);
    hsl2rgb_pkg::hsl_pix_t px;
    px.hue        = h;
    px.saturation = s;
    px.lightness  = l;
    return px;
  endfunction

  function automatic hsl2rgb_pkg::hsl_pix_t random_pixel();
    logic [hsl2rgb_pkg::FIELD_W-1:0] s;
    s = ($urandom_range(0, 15) == 0) ? '0 : pick_field();
    return make_hsl(pick_field(), s, pick_field());
  endfunction

  // offer one pixel from a falling edge, hold it until the transfer, then idle if with_gap asks for it
  task automatic push_pixel(input hsl2rgb_pkg::hsl_pix_t px, input bit with_gap);
    int unsigned gap;
    in_data  <= px;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    gap = with_gap ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data  <= random_pixel();
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic push_random(input int count, input bit with_gap);
    for (int i = 0; i < count; i++) begin
      push_pixel(random_pixel(), with_gap);
    end
  endtask

  // output side: random stalls, a long hold-off on request, or none at all
  initial begin
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned hold_left;
    stall_left = 0;
    free_left  = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_stall   <= 1'b1;
      end else if (rx_no_idle) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        free_left  = idle_length();
        stall_left = idle_length();
        out_stall <= 1'b0;
      end
    end
  end

  // transfer monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_pixel(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_pixel(out_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, sb.pending());
    $display("FAIL hsl_to_rgb_convert");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned h;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    sb       = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // gray pixels, full-scale clipping, lightness around one half, tiny saturation
    push_pixel(make_hsl(16'h0000, 16'h0000, 16'h0000), 1'b1);
    push_pixel(make_hsl(16'h0000, 16'h0000, 16'hffff), 1'b1);
    push_pixel(make_hsl(16'hffff, 16'h0000, 16'h1234), 1'b1);
    push_pixel(make_hsl(16'h0000, 16'hffff, 16'hffff), 1'b1);
    push_pixel(make_hsl(16'h5555, 16'hffff, 16'hffff), 1'b1);
    push_pixel(make_hsl(16'h0000, 16'hffff, 16'h0000), 1'b1);
    push_pixel(make_hsl(16'h0000, 16'hffff, 16'h7fff), 1'b1);
    push_pixel(make_hsl(16'h0000, 16'hffff, 16'h8000), 1'b1);
    push_pixel(make_hsl(16'h2000, 16'h0001, 16'h8000), 1'b1);
    // hue on and just past each sixth of the circle
    for (int k = 0; k < 6; k++) begin
      h = (k * 65536) / 6;
      push_pixel(make_hsl(hsl2rgb_pkg::FIELD_W'(h), 16'hffff, 16'h8000), 1'b1);
      push_pixel(make_hsl(hsl2rgb_pkg::FIELD_W'(h + 1), 16'hffff, 16'h8000), 1'b1);
    end
    push_pixel(make_hsl(16'hffff, 16'hffff, 16'h8000), 1'b1);

    // random pixels with idling on both sides
    push_random(600, 1'b1);

    // long output hold-off while input keeps coming, so the block backs up
    hold_off_req = 1'b1;
    push_random(40, 1'b0);

    // sender pauses until everything has drained
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);

    // back-to-back burst with no stalls
    rx_no_idle = 1'b1;
    push_random(400, 1'b0);
    rx_no_idle = 1'b0;

    push_random(560, 1'b1);
    in_valid <= 1'b0;

    // drain and look for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d pixels (%0d gray, %0d reaching full scale), %0d results checked",
             sb.n_in, sb.n_gray, sb.n_full, sb.n_out);
    $display("included hue breakpoints, clipping, a %0d-cycle output hold-off and bursts",
             HOLD_CYCLES);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("PASS hsl_to_rgb_convert");
    end else begin
      $display("%0d errors, %0d results missing", sb.n_errors, sb.pending());
      $display("FAIL hsl_to_rgb_convert");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hsl2rgb_pkg.sv
hw/rtl/hsl2rgb_front.sv
hw/rtl/hsl2rgb_queue.sv
hw/rtl/hsl2rgb_back.sv
hw/rtl/hsl_to_rgb_convert.sv
tb/tb_top.sv
